// ===== sv/lcpb_pkg.sv =====
// lcpb_pkg: shared types and codes of the linked-cell packet buffer
// no dependencies; used by the interfaces, the top level and the checker
package lcpb_pkg;

  localparam int OP_W     = 3;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 15;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 3'd0,
    OP_END   = 3'd1,
    OP_READ  = 3'd2,
    OP_DROP  = 3'd3,
    OP_FLUSH = 3'd4,
    OP_QUERY = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_NO_END   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_FETCH,
    S_CELL,
    S_DATA,
    S_HEAD,
    S_DONE
  } state_t;

endpackage

// ===== sv/lcpb_cmd_if.sv =====
// lcpb_cmd_if: command channel of the packet buffer (operation and byte)
// depends on lcpb_pkg
interface lcpb_cmd_if import lcpb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, operation, data_byte, input ready);
  modport sink (input valid, operation, data_byte, output ready);
endinterface

// ===== sv/lcpb_rsp_if.sv =====
// lcpb_rsp_if: result channel of the packet buffer
// depends on lcpb_pkg
interface lcpb_rsp_if import lcpb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   read_data;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    head_packet_length;
  logic [LEN_W-1:0]    total_length;

  modport source (output valid, read_data, status, head_packet_length, total_length,
                  input ready);
  modport sink (input valid, read_data, status, head_packet_length, total_length,
                output ready);
endinterface

// ===== sv/lcpb_ram.sv =====
// lcpb_ram: synchronous memory, one write port, one read port with enable
// registered read data holds while the read enable is low; no dependencies
module lcpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== sv/linked_cell_packet_buffer.sv =====
// Linked-cell packet buffer. Bytes live in CELL_COUNT cells of CELL_BYTES bytes; packets
// are a FIFO of descriptors and each packet is a chain of cells, both drawn from free
// pools. One operation per item, one result per item. The block handles one item at a
// time: every step waits on the registered read of the link, offset, descriptor or
// data memory before it can choose the next address. A flush rewrites both free chains
// one entry per cycle. After reset the same pass runs before the first item is taken.
// The result register lets a finished result wait while the next item is accepted.
// depends on lcpb_pkg, lcpb_cmd_if, lcpb_rsp_if, lcpb_ram
module linked_cell_packet_buffer import lcpb_pkg::*; #(
  parameter int CELL_BYTES = 256,
  parameter int CELL_COUNT = 64
) (
  input logic          clk,
  input logic          rst,
  lcpb_cmd_if.sink     cmd,
  lcpb_rsp_if.source   rsp
);
  localparam int CW = $clog2(CELL_COUNT);
  localparam int NW = $clog2(CELL_COUNT + 1);
  localparam int OW = $clog2(CELL_BYTES + 1);
  localparam int AW = $clog2(CELL_BYTES * CELL_COUNT);

  typedef logic [CW-1:0] idx_t;
  typedef struct packed {
    logic [OW-1:0] rd;
    logic [OW-1:0] wr;
  } offs_t;
  typedef struct packed {
    idx_t             first;
    idx_t             last;
    logic [LEN_W-1:0] count;
    logic             closed;
    logic [NW-1:0]    ncells;
  } pkt_t;

  // sequencer and operation registers
  state_t state, state_next;
  op_t op, op_next;
  logic [BYTE_W-1:0] byte_in, byte_in_next;
  status_t res_status, res_status_next;
  logic [BYTE_W-1:0] res_byte, res_byte_next;
  idx_t sweep_idx, sweep_idx_next, sweep_succ;
  logic sweep_op, sweep_op_next;

  // packet queue and the two free pools
  idx_t q_head, q_head_next, q_tail, q_tail_next, prev_tail, prev_tail_next;
  logic [NW-1:0] q_count, q_count_next;
  idx_t fc_head, fc_head_next, fc_tail, fc_tail_next;
  logic [NW-1:0] fc_count, fc_count_next;
  idx_t fp_head, fp_head_next, fp_tail, fp_tail_next;
  logic [NW-1:0] fp_count, fp_count_next;
  logic [LEN_W-1:0] total, total_next;

  // memory ports
  logic cn_we, cn_re, pn_we, pn_re, co_we, co_re, pm_we, pm_re, dm_we, dm_re;
  idx_t cn_waddr, cn_raddr, pn_waddr, pn_raddr, co_waddr, co_raddr, pm_waddr, pm_raddr;
  idx_t cn_wdata, cn_q, pn_wdata, pn_q;
  offs_t co_wdata, co_q;
  pkt_t pm_wdata, pm_q;
  logic [AW-1:0] dm_waddr, dm_raddr;
  logic [BYTE_W-1:0] dm_q;
  logic [OW-1:0] rd_inc;

  // result register
  logic out_load, out_valid;
  logic [LEN_W-1:0] head_len;

  // cell links, cell offsets, descriptors, packet links, cell bytes
  lcpb_ram #(.WIDTH(CW), .DEPTH(CELL_COUNT)) u_cell_next (
    .clk, .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata),
    .re(cn_re), .raddr(cn_raddr), .rdata(cn_q));
  lcpb_ram #(.WIDTH(2 * OW), .DEPTH(CELL_COUNT)) u_cell_offs (
    .clk, .we(co_we), .waddr(co_waddr), .wdata(co_wdata),
    .re(co_re), .raddr(co_raddr), .rdata(co_q));
  lcpb_ram #(.WIDTH($bits(pkt_t)), .DEPTH(CELL_COUNT)) u_pkt_desc (
    .clk, .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .re(pm_re), .raddr(pm_raddr), .rdata(pm_q));
  lcpb_ram #(.WIDTH(CW), .DEPTH(CELL_COUNT)) u_pkt_next (
    .clk, .we(pn_we), .waddr(pn_waddr), .wdata(pn_wdata),
    .re(pn_re), .raddr(pn_raddr), .rdata(pn_q));
  lcpb_ram #(.WIDTH(BYTE_W), .DEPTH(CELL_BYTES * CELL_COUNT)) u_cell_data (
    .clk, .we(dm_we), .waddr(dm_waddr), .wdata(byte_in),
    .re(dm_re), .raddr(dm_raddr), .rdata(dm_q));

  assign sweep_succ = (sweep_idx == idx_t'(CELL_COUNT - 1)) ? '0 : sweep_idx + idx_t'(1);
  assign rd_inc     = co_q.rd + OW'(1);
  assign head_len   = (q_count != '0 && pm_q.closed) ? pm_q.count : '0;
  assign cmd.ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep_idx <= '0;
      sweep_op  <= 1'b0;
      q_head    <= '0;
      q_tail    <= '0;
      prev_tail <= '0;
      q_count   <= '0;
      fc_head   <= '0;
      fc_tail   <= idx_t'(CELL_COUNT - 1);
      fc_count  <= NW'(CELL_COUNT);
      fp_head   <= '0;
      fp_tail   <= idx_t'(CELL_COUNT - 1);
      fp_count  <= NW'(CELL_COUNT);
      total     <= '0;
    end else begin
      state     <= state_next;
      sweep_idx <= sweep_idx_next;
      sweep_op  <= sweep_op_next;
      q_head    <= q_head_next;
      q_tail    <= q_tail_next;
      prev_tail <= prev_tail_next;
      q_count   <= q_count_next;
      fc_head   <= fc_head_next;
      fc_tail   <= fc_tail_next;
      fc_count  <= fc_count_next;
      fp_head   <= fp_head_next;
      fp_tail   <= fp_tail_next;
      fp_count  <= fp_count_next;
      total     <= total_next;
    end
  end

  // operation payload, no reset needed
  always_ff @(posedge clk) begin
    op         <= op_next;
    byte_in    <= byte_in_next;
    res_status <= res_status_next;
    res_byte   <= res_byte_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    byte_in_next    = byte_in;
    res_status_next = res_status;
    res_byte_next   = res_byte;
    sweep_idx_next  = sweep_idx;
    sweep_op_next   = sweep_op;
    q_head_next     = q_head;
    q_tail_next     = q_tail;
    prev_tail_next  = prev_tail;
    q_count_next    = q_count;
    fc_head_next    = fc_head;
    fc_tail_next    = fc_tail;
    fc_count_next   = fc_count;
    fp_head_next    = fp_head;
    fp_tail_next    = fp_tail;
    fp_count_next   = fp_count;
    total_next      = total;
    cn_we = 1'b0; cn_waddr = '0; cn_wdata = '0; cn_re = 1'b0; cn_raddr = '0;
    pn_we = 1'b0; pn_waddr = '0; pn_wdata = '0; pn_re = 1'b0; pn_raddr = '0;
    co_we = 1'b0; co_waddr = '0; co_wdata = '0; co_re = 1'b0; co_raddr = '0;
    pm_we = 1'b0; pm_waddr = '0; pm_wdata = '0; pm_re = 1'b0; pm_raddr = '0;
    dm_we = 1'b0; dm_waddr = '0; dm_re = 1'b0; dm_raddr = '0;
    out_load = 1'b0;

    unique case (state)
      // rebuild both free chains as 0, 1, ..., CELL_COUNT-1
      S_SWEEP: begin
        cn_we          = 1'b1;
        cn_waddr       = sweep_idx;
        cn_wdata       = sweep_succ;
        pn_we          = 1'b1;
        pn_waddr       = sweep_idx;
        pn_wdata       = sweep_succ;
        sweep_idx_next = sweep_succ;
        if (sweep_idx == idx_t'(CELL_COUNT - 1)) begin
          state_next = sweep_op ? S_HEAD : S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd.valid) begin
          op_next         = op_t'(cmd.operation);
          byte_in_next    = cmd.data_byte;
          res_status_next = ST_OK;
          res_byte_next   = '0;
          if (op_t'(cmd.operation) == OP_FLUSH) begin
            q_head_next    = '0;
            q_tail_next    = '0;
            q_count_next   = '0;
            fc_head_next   = '0;
            fc_tail_next   = idx_t'(CELL_COUNT - 1);
            fc_count_next  = NW'(CELL_COUNT);
            fp_head_next   = '0;
            fp_tail_next   = idx_t'(CELL_COUNT - 1);
            fp_count_next  = NW'(CELL_COUNT);
            total_next     = '0;
            sweep_idx_next = '0;
            sweep_op_next  = 1'b1;
            state_next     = S_SWEEP;
          end else begin
            // read side works on the head packet, the rest on the tail
            pm_re      = 1'b1;
            pm_raddr   = (op_t'(cmd.operation) == OP_READ) ? q_head : q_tail;
            pn_re      = 1'b1;
            pn_raddr   = (op_t'(cmd.operation) == OP_READ) ? q_head : fp_head;
            cn_re      = 1'b1;
            cn_raddr   = fc_head;
            state_next = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        state_next = S_HEAD;
        unique case (op)
          OP_WRITE: begin
            if (q_count == '0 || pm_q.closed) begin
              if (fc_count == '0 || fp_count == '0) begin
                res_status_next = ST_NO_SPACE;
              end else begin
                // open a packet together with its first cell
                pm_we           = 1'b1;
                pm_waddr        = fp_head;
                pm_wdata.first  = fc_head;
                pm_wdata.last   = fc_head;
                pm_wdata.count  = LEN_W'(1);
                pm_wdata.closed = 1'b0;
                pm_wdata.ncells = NW'(1);
                co_we           = 1'b1;
                co_waddr        = fc_head;
                co_wdata.rd     = '0;
                co_wdata.wr     = OW'(1);
                dm_we           = 1'b1;
                dm_waddr        = AW'(fc_head) * AW'(CELL_BYTES);
                if (q_count == '0) begin
                  q_head_next = fp_head;
                end else begin
                  pn_we    = 1'b1;
                  pn_waddr = q_tail;
                  pn_wdata = fp_head;
                end
                prev_tail_next = q_tail;
                q_tail_next    = fp_head;
                q_count_next   = q_count + NW'(1);
                fp_head_next   = pn_q;
                fp_count_next  = fp_count - NW'(1);
                fc_head_next   = cn_q;
                fc_count_next  = fc_count - NW'(1);
                total_next     = total + LEN_W'(1);
              end
            end else begin
              co_re      = 1'b1;
              co_raddr   = pm_q.last;
              state_next = S_CELL;
            end
          end
          OP_END: begin
            if (q_count == '0) begin
              res_status_next = ST_NO_END;
            end else begin
              pm_we           = 1'b1;
              pm_waddr        = q_tail;
              pm_wdata        = pm_q;
              pm_wdata.closed = 1'b1;
            end
          end
          OP_READ: begin
            if (q_count == '0) begin
              res_status_next = ST_EMPTY;
            end else begin
              co_re      = 1'b1;
              co_raddr   = pm_q.first;
              cn_re      = 1'b1;
              cn_raddr   = pm_q.first;
              state_next = S_CELL;
            end
          end
          OP_DROP: begin
            if (q_count != '0 && !pm_q.closed) begin
              // the whole cell chain joins the free pool in one splice
              if (fc_count == '0) begin
                fc_head_next = pm_q.first;
              end else begin
                cn_we    = 1'b1;
                cn_waddr = fc_tail;
                cn_wdata = pm_q.first;
              end
              fc_tail_next  = pm_q.last;
              fc_count_next = fc_count + pm_q.ncells;
              total_next    = total - pm_q.count;
              if (q_count == NW'(1)) begin
                q_count_next = '0;
              end else begin
                q_tail_next  = prev_tail;
                q_count_next = q_count - NW'(1);
              end
              if (fp_count == '0) begin
                fp_head_next = q_tail;
              end else begin
                pn_we    = 1'b1;
                pn_waddr = fp_tail;
                pn_wdata = q_tail;
              end
              fp_tail_next  = q_tail;
              fp_count_next = fp_count + NW'(1);
            end
          end
          default: begin
          end
        endcase
      end

      S_CELL: begin
        if (op == OP_WRITE) begin
          state_next = S_HEAD;
          if (co_q.wr >= OW'(CELL_BYTES)) begin
            if (fc_count == '0) begin
              res_status_next = ST_NO_SPACE;
            end else begin
              // tail cell full: chain a fresh cell behind it
              cn_we           = 1'b1;
              cn_waddr        = pm_q.last;
              cn_wdata        = fc_head;
              pm_we           = 1'b1;
              pm_waddr        = q_tail;
              pm_wdata        = pm_q;
              pm_wdata.last   = fc_head;
              pm_wdata.count  = pm_q.count + LEN_W'(1);
              pm_wdata.ncells = pm_q.ncells + NW'(1);
              co_we           = 1'b1;
              co_waddr        = fc_head;
              co_wdata.rd     = '0;
              co_wdata.wr     = OW'(1);
              dm_we           = 1'b1;
              dm_waddr        = AW'(fc_head) * AW'(CELL_BYTES);
              fc_head_next    = cn_q;
              fc_count_next   = fc_count - NW'(1);
              total_next      = total + LEN_W'(1);
            end
          end else begin
            co_we          = 1'b1;
            co_waddr       = pm_q.last;
            co_wdata.rd    = co_q.rd;
            co_wdata.wr    = co_q.wr + OW'(1);
            dm_we          = 1'b1;
            dm_waddr       = AW'(pm_q.last) * AW'(CELL_BYTES) + AW'(co_q.wr);
            pm_we          = 1'b1;
            pm_waddr       = q_tail;
            pm_wdata       = pm_q;
            pm_wdata.count = pm_q.count + LEN_W'(1);
            total_next     = total + LEN_W'(1);
          end
        end else begin
          dm_re      = 1'b1;
          dm_raddr   = AW'(pm_q.first) * AW'(CELL_BYTES) + AW'(co_q.rd);
          state_next = S_DATA;
        end
      end

      // read completes: pop the byte, free the cell once it is empty and maybe the packet
      S_DATA: begin
        res_byte_next  = dm_q;
        co_we          = 1'b1;
        co_waddr       = pm_q.first;
        co_wdata.rd    = rd_inc;
        co_wdata.wr    = co_q.wr;
        pm_we          = 1'b1;
        pm_waddr       = q_head;
        pm_wdata       = pm_q;
        pm_wdata.count = pm_q.count - LEN_W'(1);
        total_next     = total - LEN_W'(1);
        if (rd_inc >= co_q.wr) begin
          if (fc_count == '0) begin
            fc_head_next = pm_q.first;
          end else begin
            cn_we    = 1'b1;
            cn_waddr = fc_tail;
            cn_wdata = pm_q.first;
          end
          fc_tail_next  = pm_q.first;
          fc_count_next = fc_count + NW'(1);
          if (pm_q.first == pm_q.last) begin
            q_head_next  = pn_q;
            q_count_next = q_count - NW'(1);
            if (fp_count == '0) begin
              fp_head_next = q_head;
            end else begin
              pn_we    = 1'b1;
              pn_waddr = fp_tail;
              pn_wdata = q_head;
            end
            fp_tail_next  = q_head;
            fp_count_next = fp_count + NW'(1);
          end else begin
            pm_wdata.first  = cn_q;
            pm_wdata.ncells = pm_q.ncells - NW'(1);
          end
        end
        state_next = S_HEAD;
      end

      // fetch the head descriptor for the reported head length
      S_HEAD: begin
        pm_re      = 1'b1;
        pm_raddr   = q_head;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result register parts the block from the sink
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.read_data          <= res_byte;
      rsp.status             <= res_status;
      rsp.head_packet_length <= head_len;
      rsp.total_length       <= total;
    end
  end

  assign rsp.valid = out_valid;
endmodule

// ===== sv/lcpb_checker.sv =====
// lcpb_checker: port-level assertions for the linked-cell packet buffer
// depends on lcpb_pkg; bound to linked_cell_packet_buffer below
module lcpb_checker import lcpb_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [BYTE_W-1:0]   read_data,
  input logic [STATUS_W-1:0] status,
  input logic [LEN_W-1:0]    head_packet_length,
  input logic [LEN_W-1:0]    total_length
);
  // result held while stalled
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(status)
      && $stable(total_length))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("item accepted while busy");

  // empty read means nothing is held
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_EMPTY |-> total_length == '0 && read_data == '0
      && head_packet_length == '0)
    else $error("empty status with data held");

  a_no_end: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_NO_END |-> total_length == '0 && head_packet_length == '0)
    else $error("nothing-to-end status with data held");

  // a popped byte only comes with an ok status
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && read_data != '0 |-> status == ST_OK)
    else $error("read data with failing status");
endmodule

bind linked_cell_packet_buffer lcpb_checker u_lcpb_checker (
  .clk                (clk),
  .rst                (rst),
  .cmd_valid          (cmd.valid),
  .cmd_ready          (cmd.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .read_data          (rsp.read_data),
  .status             (rsp.status),
  .head_packet_length (rsp.head_packet_length),
  .total_length       (rsp.total_length)
);
